// ===== rtl/pcm_pkg.sv =====
package pcm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_MAP    = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic [1:0] REG_PALETTE_COUNT = 2'd0;
  localparam logic [1:0] REG_SMOOTH_WEIGHT = 2'd1;

  localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;
  localparam logic [23:0] CNT_MAX = 24'hFF_FFFF;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] entry_slot;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [3:0] entry_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_MUL,
    ST_LOAD_WR,
    ST_MAP_RD,
    ST_MAP_CMP,
    ST_MAP_ACC,
    ST_MAP_WR,
    ST_FIN_RD,
    ST_FIN_DIV,
    ST_FIN_MUL,
    ST_FIN_WR
  } state_e;

endpackage

// ===== rtl/pcm_ram.sv =====
module pcm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/pcm_div.sv =====
// Restoring divider, one quotient bit per cycle; result saturated to 8 bits.
module pcm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [23:0] divisor_i,
  output logic [7:0]  quot_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [31:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [23:0] den_q, den_d;
  logic [32:0] trial;

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    trial = {rem_q[31:0], num_q[31]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = 6'd32;
      num_d = dividend_i;
      rem_d = '0;
      quo_d = '0;
      den_d = divisor_i;
    end else if (run_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (trial >= {9'd0, den_q}) begin
        rem_d = trial - {9'd0, den_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quot_o = (quo_q > 32'd255) ? 8'hFF : quo_q[7:0];

endmodule

// ===== rtl/pcm_front.sv =====
// Front end: accepts commands and queues them for the back end.
module pcm_front #(
  parameter int QDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  pcm_pkg::in_item_t in_item_i,
  output logic              busy_o,
  output logic              q_valid_o,
  output pcm_pkg::in_item_t q_item_o,
  input  logic              q_pop_i
);
  import pcm_pkg::*;

  localparam int PW = $clog2(QDepth);

  in_item_t       buf_q [QDepth];
  logic [PW-1:0]  wp_q, rp_q;
  logic [PW:0]    cnt_q;
  logic           push;

  assign busy_o    = (cnt_q == (PW+1)'(QDepth));
  // Unused codes never reach the back end.
  assign push      = start_i && !busy_o && (in_item_i.operation != OP_NONE);
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = buf_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + PW'(1);
      if (q_pop_i) rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_item_i;
  end

endmodule

// ===== rtl/pcm_back.sv =====
// Back end: palette memories, sequential search, accumulation and finish.
module pcm_back #(
  parameter int PaletteDepth = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [4:0]         palette_count_i,
  input  logic [7:0]         smooth_weight_i,
  input  logic               q_valid_i,
  input  pcm_pkg::in_item_t  q_item_i,
  output logic               q_pop_o,
  output logic               res_valid_o,
  output pcm_pkg::out_item_t res_o
);
  import pcm_pkg::*;

  localparam int AW  = $clog2(PaletteDepth);
  localparam int CAP = (PaletteDepth < 16) ? PaletteDepth : 16;

  state_e state_q, state_d;

  in_item_t       item_q;
  logic [AW-1:0]  idx_q, idx_d;
  logic [AW-1:0]  best_q, best_d;
  logic [17:0]    dbest_q, dbest_d;
  logic [AW:0]    n_act;
  logic [1:0]     ch_q, ch_d;
  logic [23:0]    newc_q, newc_d;
  logic           div_start;
  logic [5:0]     wait_q, wait_d;

  // memories
  logic           col_we, sum_we;
  logic [AW-1:0]  col_waddr, sum_waddr, raddr;
  logic [23:0]    col_wdata, col_rdata;
  logic [119:0]   sum_wdata, sum_rdata;

  // active entry count
  always_comb begin
    if (palette_count_i == 5'd0) n_act = (AW+1)'(1);
    else if (32'(palette_count_i) > CAP) n_act = (AW+1)'(CAP);
    else n_act = (AW+1)'(palette_count_i);
  end

  pcm_ram #(.Width(24), .Depth(PaletteDepth)) u_col (
    .clk_i, .we_i(col_we), .waddr_i(col_waddr), .wdata_i(col_wdata),
    .raddr_i(raddr), .rdata_o(col_rdata)
  );
  pcm_ram #(.Width(120), .Depth(PaletteDepth)) u_sum (
    .clk_i, .we_i(sum_we), .waddr_i(sum_waddr), .wdata_i(sum_wdata),
    .raddr_i(raddr), .rdata_o(sum_rdata)
  );

  // distance of current read entry
  logic [8:0]  dr, dg, db;
  logic [17:0] dist_cur;
  always_comb begin
    dr = {1'b0, item_q.in_red}   - {1'b0, col_rdata[23:16]};
    dg = {1'b0, item_q.in_green} - {1'b0, col_rdata[15:8]};
    db = {1'b0, item_q.in_blue}  - {1'b0, col_rdata[7:0]};
    if (dr[8]) dr = -dr;
    if (dg[8]) dg = -dg;
    if (db[8]) db = -db;
    dist_cur = 18'(dr[7:0]) * 18'(dr[7:0]) + 18'(dg[7:0]) * 18'(dg[7:0])
             + 18'(db[7:0]) * 18'(db[7:0]);
  end

  // seed products, registered
  logic [7:0]  w;
  logic [23:0] seed_c;
  logic [95:0] seed_q;
  assign w = (smooth_weight_i != 8'd0) ? smooth_weight_i - 8'd1 : 8'd0;
  always_ff @(posedge clk_i) begin
    seed_q <= {{16'd0, 16'(seed_c[23:16]) * 16'(w)}, {16'd0, 16'(seed_c[15:8]) * 16'(w)},
               {16'd0, 16'(seed_c[7:0]) * 16'(w)}};
  end

  // saturating accumulate
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? SUM_MAX : s[31:0];
  endfunction

  // divider
  logic [31:0] div_num;
  logic [7:0]  div_quo;
  always_comb begin
    unique case (ch_q)
      2'd0:    div_num = sum_rdata[119:88];
      2'd1:    div_num = sum_rdata[87:56];
      default: div_num = sum_rdata[55:24];
    endcase
  end
  pcm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_num),
    .divisor_i(sum_rdata[23:0]), .quot_o(div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_item_i.operation)
            OP_LOAD:   state_d = ST_LOAD_MUL;
            OP_MAP:    state_d = ST_MAP_RD;
            OP_FINISH: state_d = ST_FIN_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD_RD:  state_d = ST_LOAD_MUL;
      ST_LOAD_MUL: state_d = ST_LOAD_WR;
      ST_LOAD_WR:  state_d = ST_IDLE;
      ST_MAP_RD:   state_d = ST_MAP_CMP;
      ST_MAP_CMP:  state_d = (32'(idx_q) + 1 == 32'(n_act)) ? ST_MAP_ACC : ST_MAP_CMP;
      ST_MAP_ACC:  state_d = ST_MAP_WR;
      ST_MAP_WR:   state_d = ST_IDLE;
      ST_FIN_RD:   state_d = ST_FIN_DIV;
      ST_FIN_DIV:  state_d = (ch_q == 2'd2 && wait_q == 6'd0) ? ST_FIN_MUL : ST_FIN_DIV;
      ST_FIN_MUL:  state_d = ST_FIN_WR;
      ST_FIN_WR:   state_d = (32'(idx_q) + 1 == 32'(n_act)) ? ST_IDLE : ST_FIN_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    q_pop_o     = 1'b0;
    idx_d       = idx_q;
    best_d      = best_q;
    dbest_d     = dbest_q;
    ch_d        = ch_q;
    newc_d      = newc_q;
    wait_d      = wait_q;
    div_start   = 1'b0;
    raddr       = idx_q;
    col_we      = 1'b0;
    sum_we      = 1'b0;
    col_waddr   = idx_q;
    sum_waddr   = idx_q;
    col_wdata   = newc_q;
    sum_wdata   = {seed_q, 16'd0, w};
    seed_c      = newc_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        q_pop_o = q_valid_i;
        idx_d   = '0;
        raddr   = '0;
        newc_d  = {q_item_i.in_red, q_item_i.in_green, q_item_i.in_blue};
      end
      ST_LOAD_RD, ST_LOAD_MUL: ;
      ST_LOAD_WR: begin
        col_waddr = AW'(item_q.entry_slot);
        sum_waddr = AW'(item_q.entry_slot);
        col_we    = (32'(item_q.entry_slot) < PaletteDepth);
        sum_we    = col_we;
      end
      ST_MAP_RD: ;
      ST_MAP_CMP: begin
        if (idx_q == '0 || dist_cur < dbest_q) begin
          dbest_d = dist_cur;
          best_d  = idx_q;
          newc_d  = col_rdata;
        end
        idx_d = idx_q + AW'(1);
        raddr = idx_q + AW'(1);
      end
      ST_MAP_ACC: raddr = best_q;
      ST_MAP_WR: begin
        sum_waddr = best_q;
        sum_we    = (smooth_weight_i != 8'd0);
        sum_wdata = {sat_add(sum_rdata[119:88], item_q.in_red),
                     sat_add(sum_rdata[87:56], item_q.in_green),
                     sat_add(sum_rdata[55:24], item_q.in_blue),
                     (sum_rdata[23:0] < CNT_MAX) ? sum_rdata[23:0] + 24'd1 : CNT_MAX};
        res_valid_o = 1'b1;
        res_o = '{entry_index: 4'(best_q), out_red: newc_q[23:16],
                  out_green: newc_q[15:8], out_blue: newc_q[7:0], last_of_run: 1'b1};
      end
      ST_FIN_RD: begin
        ch_d   = 2'd0;
        wait_d = 6'd33;
      end
      ST_FIN_DIV: begin
        newc_d = col_rdata;
        if (wait_q == 6'd33) div_start = 1'b1;
        if (wait_q != 6'd0) wait_d = wait_q - 6'd1;
        if (wait_q == 6'd0) begin
          if (smooth_weight_i != 8'd0 && sum_rdata[23:0] != 24'd0) begin
            newc_d = newc_q;
            unique case (ch_q)
              2'd0:    newc_d[23:16] = div_quo;
              2'd1:    newc_d[15:8]  = div_quo;
              default: newc_d[7:0]   = div_quo;
            endcase
          end
          if (ch_q != 2'd2) begin
            ch_d   = ch_q + 2'd1;
            wait_d = 6'd33;
          end
        end else if (wait_q != 6'd33 || ch_q != 2'd0) begin
          newc_d = newc_q;
        end
      end
      ST_FIN_MUL: ;
      ST_FIN_WR: begin
        col_we = 1'b1;
        sum_we = 1'b1;
        raddr  = idx_q + AW'(1);
        idx_d  = idx_q + AW'(1);
        res_valid_o = 1'b1;
        res_o = '{entry_index: 4'(idx_q), out_red: newc_q[23:16],
                  out_green: newc_q[15:8], out_blue: newc_q[7:0],
                  last_of_run: (32'(idx_q) + 1 == 32'(n_act))};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      ch_q       <= '0;
      wait_q     <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      ch_q       <= ch_d;
      wait_q     <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    dbest_q <= dbest_d;
    newc_q  <= newc_d;
    if (state_q == ST_IDLE && q_valid_i) item_q <= q_item_i;
  end

endmodule

// ===== rtl/palette_color_mapper_unit.sv =====
// Nearest-color palette mapper. A load writes one palette entry; a map
// searches one palette entry per cycle through the color memory read port,
// over the active entries; a finish runs three serial divisions per active
// entry. A two-deep command queue lets commands wait while the back end
// works; busy rises only when both slots are full. Results appear for one
// cycle with res_valid_o and must be taken then; the receiver cannot stall
// the block.
module palette_color_mapper_unit #(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pcm_pkg::in_item_t  in_item_i,
  output logic               res_valid_o,
  output pcm_pkg::out_item_t res_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_wdata_i
);
  import pcm_pkg::*;

  logic [4:0] palette_count_q;
  logic [7:0] smooth_weight_q;
  logic       q_valid, q_pop;
  in_item_t   q_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_count_q <= 5'd16;
      smooth_weight_q <= 8'd0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_PALETTE_COUNT) palette_count_q <= cfg_wdata_i[4:0];
      if (cfg_index_i == REG_SMOOTH_WEIGHT) smooth_weight_q <= cfg_wdata_i;
    end
  end

  pcm_front u_front (
    .clk_i, .rst_ni, .start_i(start), .in_item_i, .busy_o(busy),
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  pcm_back #(.PaletteDepth(PALETTE_DEPTH)) u_back (
    .clk_i, .rst_ni, .palette_count_i(palette_count_q),
    .smooth_weight_i(smooth_weight_q), .q_valid_i(q_valid), .q_item_i(q_item),
    .q_pop_o(q_pop), .res_valid_o, .res_o
  );

endmodule
